// ===== src/gpa_pkg.sv =====
// gpa_pkg: shared types and constants for the gravity pair accumulator
// holds the port payload structs, the front-to-back work item and the back state codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gpa_pkg;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic        [31:0] source_mass;
        logic               first;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [47:0] accel_x;
        logic signed [47:0] accel_y;
    } result_t;

    // classified request: distance magnitudes and signs, ready for the back end
    typedef struct packed {
        logic [31:0] adx;
        logic [31:0] ady;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] mass;
        logic        first;
        logic        last;
    } work_t;

    typedef struct packed {
        logic [31:0] grav;
        logic [31:0] eps_sq;
    } cfg_t;

    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_GRAV = 2'd0;
    localparam cfg_idx_t REG_SOFT = 2'd1;

    localparam logic signed [65:0] SUM_MAX = 66'sd140737488355327;
    localparam logic signed [65:0] SUM_MIN = -66'sd140737488355328;
    localparam logic [63:0] MAG_LIM = 64'h0001_0000_0000_0000;
    // numerator of the reciprocal, 2^61 - 1, split at bit 32
    localparam logic [34:0] DIV_REM_INIT = 35'h1FFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_GM,
        S_CHK,
        S_NORM,
        S_SQRT,
        S_PMUL,
        S_DIV,
        S_GNORM,
        S_SCMUL,
        S_CNORM,
        S_TMUL,
        S_SCALE,
        S_ACC,
        S_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/gpa_queue.sv =====
// gpa_queue: small register queue with push/full and pop/empty
// generic over width and depth, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module gpa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/gpa_front.sv =====
// gpa_front: accepts requests, forms distance magnitudes and signs, queues them
// depends on gpa_pkg and gpa_queue
`timescale 1ns / 1ps
`default_nettype none

module gpa_front #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gpa_pkg::item_t item,
    output logic                full,
    output gpa_pkg::work_t      work,
    output logic                work_valid,
    input  wire logic           work_pop
);

    logic signed [32:0] dx, dy;
    logic [32:0]        abs_x, abs_y;
    gpa_pkg::work_t     cls;
    logic               q_empty;

    always_comb
    begin
        dx    = {item.source_x[31], item.source_x} - {item.target_x[31], item.target_x};
        dy    = {item.source_y[31], item.source_y} - {item.target_y[31], item.target_y};
        abs_x = dx[32] ? (33'd0 - dx) : dx;
        abs_y = dy[32] ? (33'd0 - dy) : dy;
        // |d| never exceeds 2^32 - 1
        cls.adx   = abs_x[31:0];
        cls.ady   = abs_y[31:0];
        cls.neg_x = dx[32];
        cls.neg_y = dy[32];
        cls.mass  = item.source_mass;
        cls.first = item.first;
        cls.last  = item.last;
    end

    gpa_queue #(
        .WIDTH($bits(gpa_pkg::work_t)),
        .DEPTH(DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (work_pop),
        .rdata (work),
        .empty (q_empty)
    );

    assign work_valid = !q_empty;

endmodule

`default_nettype wire

// ===== src/gpa_back.sv =====
// gpa_back: sequencer that evaluates one softened gravity term and updates the sums
// one shared 32x32 multiplier, bit-serial square root and reciprocal; depends on gpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module gpa_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire gpa_pkg::cfg_t   cfg,
    input  wire gpa_pkg::work_t  work,
    input  wire logic            work_valid,
    output logic                 work_pop,
    input  wire logic            res_room,
    output logic                 res_push,
    output gpa_pkg::result_t     res_data
);

    localparam int FE_HALF = (FRAC_BITS + 1) / 2;
    localparam int ODD     = FRAC_BITS % 2;

    gpa_pkg::back_state_t state_reg, state_next;
    gpa_pkg::work_t       item_reg, item_next;
    logic [63:0]          r2_reg, r2_next;
    logic [63:0]          gm_reg, gm_next;
    logic signed [6:0]    j_reg, j_next;
    logic [61:0]          rad_reg, rad_next;
    logic [34:0]          rem_reg, rem_next;
    logic [30:0]          root_reg, root_next;
    logic [31:0]          p_reg, p_next;
    logic [31:0]          q_reg, q_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [5:0]           g_reg, g_next;
    logic [5:0]           c_reg, c_next;
    logic signed [9:0]    x_reg, x_next;
    logic [63:0]          mag_reg, mag_next;
    logic signed [64:0]   term_reg, term_next;
    logic                 axis_reg, axis_next;
    logic signed [47:0]   sum_x_reg, sum_x_next;
    logic signed [47:0]   sum_y_reg, sum_y_next;

    logic [31:0]          mul_a, mul_b;
    logic [63:0]          prod;
    logic [34:0]          rem_sh, trial;
    logic [32:0]          rd;
    logic [111:0]         wide;
    logic [63:0]          tmag;
    logic [9:0]           nx;
    logic signed [65:0]   acc;
    logic signed [65:0]   acc_sat;
    int                   x_int;

    always_comb
    begin
        case (state_reg)
            gpa_pkg::S_SQX:   begin mul_a = item_reg.adx;    mul_b = item_reg.adx; end
            gpa_pkg::S_SQY:   begin mul_a = item_reg.ady;    mul_b = item_reg.ady; end
            gpa_pkg::S_GM:    begin mul_a = cfg.grav;        mul_b = item_reg.mass; end
            gpa_pkg::S_PMUL:  begin mul_a = r2_reg[31:0];    mul_b = {1'b0, root_reg}; end
            gpa_pkg::S_SCMUL: begin mul_a = gm_reg[31:0];    mul_b = q_reg; end
            gpa_pkg::S_TMUL:
            begin
                mul_a = axis_reg ? item_reg.ady : item_reg.adx;
                mul_b = gm_reg[31:0];
            end
            default:          begin mul_a = '0;              mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        r2_next    = r2_reg;
        gm_next    = gm_reg;
        j_next     = j_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        g_next     = g_reg;
        c_next     = c_reg;
        x_next     = x_reg;
        mag_next   = mag_reg;
        term_next  = term_reg;
        axis_next  = axis_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        work_pop   = 1'b0;
        res_push   = 1'b0;

        rem_sh  = {rem_reg[32:0], rad_reg[61:60]};
        trial   = {2'b00, root_reg, 2'b01};
        rd      = {rem_reg[31:0], 1'b1};
        wide    = {48'd0, mag_reg} << x_reg[5:0];
        nx      = 10'd0 - x_reg;
        tmag    = '0;
        acc     = 66'(sum_x_reg) + 66'(term_reg);
        acc_sat = acc;
        x_int   = -77 - 3 * (int'(j_reg) - FE_HALF) + int'(g_reg) + int'(c_reg)
                  - 2 * FRAC_BITS;

        case (state_reg)
            gpa_pkg::S_IDLE:
            begin
                if (work_valid && res_room)
                begin
                    work_pop  = 1'b1;
                    item_next = work;
                    if (work.first)
                    begin
                        sum_x_next = '0;
                        sum_y_next = '0;
                    end
                    state_next = gpa_pkg::S_SQX;
                end
            end
            gpa_pkg::S_SQX:
            begin
                r2_next    = prod >> FRAC_BITS;
                state_next = gpa_pkg::S_SQY;
            end
            gpa_pkg::S_SQY:
            begin
                r2_next    = r2_reg + (prod >> FRAC_BITS) + {32'd0, cfg.eps_sq};
                state_next = gpa_pkg::S_GM;
            end
            gpa_pkg::S_GM:
            begin
                gm_next    = prod;
                state_next = gpa_pkg::S_CHK;
            end
            gpa_pkg::S_CHK:
            begin
                if (r2_reg == '0 || gm_reg == '0)
                begin
                    state_next = gpa_pkg::S_DONE;
                end
                else
                begin
                    r2_next    = r2_reg << ODD;
                    j_next     = '0;
                    g_next     = '0;
                    state_next = gpa_pkg::S_NORM;
                end
            end
            gpa_pkg::S_NORM:
            begin
                // bring r2 into [2^30, 2^32) two bits at a time
                if (r2_reg[63:32] != '0)
                begin
                    r2_next = r2_reg >> 2;
                    j_next  = j_reg + 7'sd1;
                end
                else if (r2_reg[31:30] == 2'b00)
                begin
                    r2_next = r2_reg << 2;
                    j_next  = j_reg - 7'sd1;
                end
                else
                begin
                    rad_next   = {r2_reg[31:0], 30'd0};
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = 6'd31;
                    state_next = gpa_pkg::S_SQRT;
                end
            end
            gpa_pkg::S_SQRT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[29:0], 1'b0};
                end
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = gpa_pkg::S_PMUL;
                end
            end
            gpa_pkg::S_PMUL:
            begin
                p_next     = prod[62:31];
                rem_next   = gpa_pkg::DIV_REM_INIT;
                q_next     = '0;
                cnt_next   = 6'd32;
                state_next = gpa_pkg::S_DIV;
            end
            gpa_pkg::S_DIV:
            begin
                // low numerator bits are all ones
                if (rd >= {1'b0, p_reg})
                begin
                    rem_next = 35'(rd - {1'b0, p_reg});
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = 35'(rd);
                    q_next   = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = gpa_pkg::S_GNORM;
                end
            end
            gpa_pkg::S_GNORM:
            begin
                if (gm_reg[63:32] != '0)
                begin
                    gm_next = gm_reg >> 1;
                    g_next  = g_reg + 6'd1;
                end
                else
                begin
                    state_next = gpa_pkg::S_SCMUL;
                end
            end
            gpa_pkg::S_SCMUL:
            begin
                gm_next    = prod;
                c_next     = '0;
                state_next = gpa_pkg::S_CNORM;
            end
            gpa_pkg::S_CNORM:
            begin
                if (gm_reg[63:32] != '0)
                begin
                    gm_next = gm_reg >> 1;
                    c_next  = c_reg + 6'd1;
                end
                else
                begin
                    x_next     = 10'(x_int);
                    axis_next  = 1'b0;
                    state_next = gpa_pkg::S_TMUL;
                end
            end
            gpa_pkg::S_TMUL:
            begin
                mag_next   = prod;
                state_next = gpa_pkg::S_SCALE;
            end
            gpa_pkg::S_SCALE:
            begin
                if (mag_reg == '0)
                begin
                    tmag = '0;
                end
                else if (!x_reg[9])
                begin
                    if (x_reg > 10'sd48)
                    begin
                        tmag = gpa_pkg::MAG_LIM;
                    end
                    else if (wide > {48'd0, gpa_pkg::MAG_LIM})
                    begin
                        tmag = gpa_pkg::MAG_LIM;
                    end
                    else
                    begin
                        tmag = wide[63:0];
                    end
                end
                else if (nx >= 10'd64)
                begin
                    tmag = '0;
                end
                else
                begin
                    tmag = mag_reg >> nx[5:0];
                end
                if (axis_reg ? item_reg.neg_y : item_reg.neg_x)
                begin
                    term_next = 65'sd0 - $signed({1'b0, tmag});
                end
                else
                begin
                    term_next = $signed({1'b0, tmag});
                end
                state_next = gpa_pkg::S_ACC;
            end
            gpa_pkg::S_ACC:
            begin
                acc = axis_reg ? (66'(sum_y_reg) + 66'(term_reg))
                               : (66'(sum_x_reg) + 66'(term_reg));
                if (acc > gpa_pkg::SUM_MAX)
                begin
                    acc_sat = gpa_pkg::SUM_MAX;
                end
                else if (acc < gpa_pkg::SUM_MIN)
                begin
                    acc_sat = gpa_pkg::SUM_MIN;
                end
                else
                begin
                    acc_sat = acc;
                end
                if (axis_reg)
                begin
                    sum_y_next = acc_sat[47:0];
                    state_next = gpa_pkg::S_DONE;
                end
                else
                begin
                    sum_x_next = acc_sat[47:0];
                    axis_next  = 1'b1;
                    state_next = gpa_pkg::S_TMUL;
                end
            end
            gpa_pkg::S_DONE:
            begin
                res_push   = item_reg.last;
                state_next = gpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gpa_pkg::S_IDLE;
            end
        endcase
    end

    assign res_data.accel_x = sum_x_reg;
    assign res_data.accel_y = sum_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gpa_pkg::S_IDLE;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        r2_reg   <= r2_next;
        gm_reg   <= gm_next;
        j_reg    <= j_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        g_reg    <= g_next;
        c_reg    <= c_next;
        x_reg    <= x_next;
        mag_reg  <= mag_next;
        term_reg <= term_next;
        axis_reg <= axis_next;
    end

endmodule

`default_nettype wire

// ===== src/gravity_pair_accumulate.sv =====
// gravity_pair_accumulate: top level of the softened 2d gravity accumulator
// depends on gpa_pkg, gpa_front, gpa_back and gpa_queue
//
// usage:
//   requests enter on push/full/item: a request is taken when push is high and
//   full is low. each carries target and source positions, source mass and the
//   first/last flags. first clears the running sums, last emits them.
//   results leave on empty/pop/result: result is valid while empty is low and
//   is removed when pop is high. cfg_valid/cfg_ready/cfg_index/cfg_data write
//   G (index 0) and softening squared (index 1); cfg_ready is always high.
// timing:
//   a request waits in the front queue until the back end takes it; the back end runs
//   one at a time: a zero term skips the arithmetic, else its time is set by the
//   31-step square root, 32-step reciprocal and the normalize loops for r^2 (up
//   to 15 shifts), G*m and the scale (up to 32 each). both queues hold two.
// reset:
//   clears both queues and the sums; G and softening squared return to 1.0.
//   a stalled result queue stops the back end before it starts a new request,
//   and the front queue then fills and raises full.
`timescale 1ns / 1ps
`default_nettype none

module gravity_pair_accumulate #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire gpa_pkg::item_t        item,
    output logic                       full,
    input  wire logic                  pop,
    output gpa_pkg::result_t           result,
    output logic                       empty,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire gpa_pkg::cfg_idx_t     cfg_index,
    input  wire logic [31:0]           cfg_data
);

    gpa_pkg::cfg_t    cfg_reg, cfg_next;
    gpa_pkg::work_t   work;
    logic             work_valid;
    logic             work_pop;
    logic             res_push;
    logic             res_full;
    gpa_pkg::result_t res_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gpa_pkg::REG_GRAV: cfg_next.grav = cfg_data;
                gpa_pkg::REG_SOFT: cfg_next.eps_sq = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grav   <= 32'd1 << FRAC_BITS;
            cfg_reg.eps_sq <= 32'd1 << FRAC_BITS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gpa_front #(
        .DEPTH(2)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .work       (work),
        .work_valid (work_valid),
        .work_pop   (work_pop)
    );

    gpa_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .work       (work),
        .work_valid (work_valid),
        .work_pop   (work_pop),
        .res_room   (!res_full),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    gpa_queue #(
        .WIDTH($bits(gpa_pkg::result_t)),
        .DEPTH(2)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ===== src/gpa_checker.sv =====
// gpa_checker: port-level assertions for gravity_pair_accumulate
// depends on gpa_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module gpa_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             push,
    input wire gpa_pkg::item_t   item,
    input wire logic             full,
    input wire logic             pop,
    input wire gpa_pkg::result_t result,
    input wire logic             empty
);

    // requests with last taken but whose result has not been popped yet
    logic [3:0] pend_reg, pend_next;
    logic       last_in, res_out;

    assign last_in = push && !full && item.last;
    assign res_out = pop && !empty;

    always_comb
    begin
        pend_next = pend_reg;
        if (last_in && !res_out)
        begin
            pend_next = pend_reg + 4'd1;
        end
        else if (res_out && !last_in)
        begin
            pend_next = pend_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    ap_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    ap_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pend_reg != 4'd0))
        else $error("result shown without a pending last request");

    ap_reset_clean: assert property (@(posedge clk)
        (rst_n && !$past(rst_n)) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule

bind gravity_pair_accumulate gpa_checker u_gpa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .item   (item),
    .full   (full),
    .pop    (pop),
    .result (result),
    .empty  (empty)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for gravity_pair_accumulate
// random and directed requests, bit-exact fixed-point force prediction, queue handshakes
// depends on gpa_pkg and the gravity_pair_accumulate rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC = 16;
    localparam gpa_pkg::cfg_idx_t REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 500;

    logic clk;
    logic rst_n;
    logic push;
    gpa_pkg::item_t item;
    logic full;
    logic pop;
    gpa_pkg::result_t result;
    logic empty;
    logic cfg_valid;
    logic cfg_ready;
    gpa_pkg::cfg_idx_t cfg_index;
    logic [31:0] cfg_data;

    gravity_pair_accumulate #(.FRAC_BITS(FRAC)) DUT (
        .clk(clk), .rst_n(rst_n),
        .push(push), .item(item), .full(full),
        .pop(pop), .result(result), .empty(empty),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    class accel_board;
        bit [31:0] grav;
        bit [31:0] eps_sq;
        longint signed sum_x;
        longint signed sum_y;
        gpa_pkg::result_t sums_due[$];
        int mismatches;
        int results_seen;
        bit failed;

        function new();
            grav = 32'd1 << FRAC;
            eps_sq = 32'd1 << FRAC;
            sum_x = 0;
            sum_y = 0;
            mismatches = 0;
            results_seen = 0;
            failed = 0;
        endfunction

        function void write_reg(gpa_pkg::cfg_idx_t idx, bit [31:0] data);
            if (idx == gpa_pkg::REG_GRAV)
                grav = data;
            else if (idx == gpa_pkg::REG_SOFT)
                eps_sq = data;
        endfunction

        function int bit_len(bit [63:0] v);
            int n;
            n = 0;
            while (v != 0)
            begin
                n++;
                v >>= 1;
            end
            return n;
        endfunction

        function bit [63:0] isqrt(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // |d|*scale shifted by x, magnitude truncated or saturated at 2^48
        function longint signed axis_term(longint signed d, bit [63:0] sc32, int x);
            bit [63:0] mag;
            bit [63:0] lim;
            lim = 64'd1 << 48;
            mag = (d < 0) ? 64'(-d) : 64'(d);
            mag = mag * sc32;
            if (mag != 0)
            begin
                if (x >= 0)
                    mag = (x >= 63 || mag > (lim >> x)) ? lim : (mag << x);
                else
                    mag = (-x >= 64) ? 64'd0 : (mag >> (-x));
            end
            return (d < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        function longint signed clamp_add(longint signed a, longint signed b);
            longint signed s;
            s = a + b;
            if (s > 64'sd140737488355327)
                return 64'sd140737488355327;
            if (s < -64'sd140737488355328)
                return -64'sd140737488355328;
            return s;
        endfunction

        function void note_item(gpa_pkg::item_t it);
            longint signed dx;
            longint signed dy;
            bit [63:0] adx, ady, r2, gm, m, s, p, inv, gm32, sc, sc32;
            int j, h, e, g, c, x, fe;
            gpa_pkg::result_t r;
            dx = longint'(it.source_x) - longint'(it.target_x);
            dy = longint'(it.source_y) - longint'(it.target_y);
            adx = (dx < 0) ? 64'(-dx) : 64'(dx);
            ady = (dy < 0) ? 64'(-dy) : 64'(dy);
            r2 = ((adx * adx) >> FRAC) + ((ady * ady) >> FRAC) + 64'(eps_sq);
            gm = 64'(grav) * 64'(it.source_mass);
            if (it.first)
            begin
                sum_x = 0;
                sum_y = 0;
            end
            if (r2 != 0 && gm != 0)
            begin
                fe = FRAC + (FRAC & 1);
                j = 0;
                if (FRAC & 1)
                    r2 <<= 1;
                m = r2;
                while (m >= (64'd1 << 32))
                begin
                    m >>= 2;
                    j++;
                end
                while (m < (64'd1 << 30))
                begin
                    m <<= 2;
                    j--;
                end
                h = j - fe / 2;
                s = isqrt(m << 30);
                p = (m * s) >> 31;
                inv = ((64'd1 << 61) - 1) / p;
                e = -77 - 3 * h;
                g = bit_len(gm) - 32;
                if (g < 0)
                    g = 0;
                gm32 = gm >> g;
                sc = gm32 * inv;
                c = bit_len(sc) - 32;
                if (c < 0)
                    c = 0;
                sc32 = sc >> c;
                x = e + g + c - 2 * FRAC;
                sum_x = clamp_add(sum_x, axis_term(dx, sc32, x));
                sum_y = clamp_add(sum_y, axis_term(dy, sc32, x));
            end
            if (it.last)
            begin
                r.accel_x = sum_x[47:0];
                r.accel_y = sum_y[47:0];
                sums_due = {sums_due, r};
            end
        endfunction

        function void check_result(gpa_pkg::result_t got);
            gpa_pkg::result_t want;
            results_seen++;
            if (sums_due.size() == 0)
            begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d", got.accel_x, got.accel_y);
                return;
            end
            want = sums_due.pop_front();
            if (got.accel_x !== want.accel_x || got.accel_y !== want.accel_y)
            begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                             want.accel_x, want.accel_y, got.accel_x, got.accel_y);
            end
        endfunction
    endclass

    accel_board board;
    bit held_off;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic gpa_pkg::item_t mk(int tx, int ty, int sx, int sy, bit [31:0] mass,
                                          bit f, bit l);
        gpa_pkg::item_t it;
        it.target_x = tx;
        it.target_y = ty;
        it.source_x = sx;
        it.source_y = sy;
        it.source_mass = mass;
        it.first = f;
        it.last = l;
        return it;
    endfunction

    task automatic send(gpa_pkg::item_t it);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_item(it);
    endtask

    task automatic cfg_write(gpa_pkg::cfg_idx_t idx, bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int rand_pos(int base, int mode);
        case (mode)
            0: return int'($urandom);
            1: return base + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: return base + $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return base;
        endcase
    endfunction

    function automatic bit [31:0] rand_mass();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0010_0000);
            2: return $urandom_range(0, 32'h0000_0400);
            default: return 32'd1 << FRAC;
        endcase
    endfunction

    // groups of first..last with random content, some loose flags as noise
    task automatic run_random(int count);
        int sent;
        int glen;
        int k;
        int burst;
        int mode;
        int tx, ty;
        bit f, l;
        gpa_pkg::item_t it;
        sent = 0;
        burst = $urandom_range(1, 20);
        while (sent < count)
        begin
            glen = $urandom_range(1, 4);
            tx = $urandom;
            ty = $urandom;
            for (k = 0; k < glen; k++)
            begin
                mode = $urandom_range(0, 3);
                f = (k == 0);
                l = (k == glen - 1);
                if ($urandom_range(0, 9) == 0)
                begin
                    f = 1'($urandom);
                    l = 1'($urandom);
                end
                it = mk(tx, ty, rand_pos(tx, mode), rand_pos(ty, mode), rand_mass(), f, l);
                send(it);
                sent++;
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 20);
                    if ($urandom_range(0, 3) != 0)
                    begin
                        push <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(posedge clk);
                    end
                end
            end
        end
        push <= 1'b0;
    endtask

    // receiver: runs of steady pop, random pop and stall, plus one long hold-off
    initial
    begin
        int len;
        int mode;
        pop <= 1'b0;
        held_off = 0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && board.results_seen >= 10)
            begin
                held_off = 1;
                pop <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            len = $urandom_range(1, 40);
            mode = $urandom_range(0, 2);
            repeat (len)
            begin
                pop <= (mode == 0) ? 1'b1 : (mode == 1) ? 1'($urandom) : 1'b0;
                @(posedge clk);
                if (pop && !empty)
                    board.check_result(result);
            end
        end
    end

    initial
    begin
        board = new();
        rst_n <= 1'b0;
        push <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= gpa_pkg::REG_GRAV;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero distance, extremes of position and mass, lone first+last, one three-item group
        send(mk(0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1));
        send(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'hFFFF_FFFF, 1, 1));
        send(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'hFFFF_FFFF, 1, 1));
        send(mk(0, 0, 32'h0001_0000, 0, 32'd0, 1, 1));
        send(mk(0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1, 1));
        send(mk(5, -5, 7, -9, 32'h0000_0001, 1, 0));
        send(mk(0, 0, 32'h0000_8000, 32'h0000_8000, 32'h0100_0000, 0, 0));
        send(mk(0, 0, -32'sh0000_8000, 32'h0000_8000, 32'h0100_0000, 0, 1));
        push <= 1'b0;
        run_random(180);
        drain();

        // strong gravity, no softening: zero distance and saturation
        cfg_write(gpa_pkg::REG_GRAV, 32'hFFFF_FFFF);
        cfg_write(gpa_pkg::REG_SOFT, 32'd0);
        cfg_write(REG_UNUSED, 32'h1234_5678);
        send(mk(100, 100, 100, 100, 32'hFFFF_FFFF, 1, 1));
        send(mk(0, 0, 1, 1, 32'hFFFF_FFFF, 1, 0));
        send(mk(0, 0, 1, 1, 32'hFFFF_FFFF, 0, 0));
        send(mk(0, 0, 1, 1, 32'hFFFF_FFFF, 0, 1));
        send(mk(0, 0, -1, -1, 32'hFFFF_FFFF, 1, 0));
        send(mk(0, 0, -1, -1, 32'hFFFF_FFFF, 0, 1));
        push <= 1'b0;
        run_random(200);
        drain();

        // no gravity, maximum softening
        cfg_write(gpa_pkg::REG_GRAV, 32'd0);
        cfg_write(gpa_pkg::REG_SOFT, 32'hFFFF_FFFF);
        send(mk(0, 0, 32'h0001_0000, 0, 32'hFFFF_FFFF, 1, 1));
        push <= 1'b0;
        run_random(100);
        drain();

        cfg_write(gpa_pkg::REG_GRAV, 32'h0001_0000);
        cfg_write(gpa_pkg::REG_SOFT, 32'hFFFF_FFFF);
        run_random(150);
        drain();

        repeat (3)
        begin
            cfg_write(gpa_pkg::REG_GRAV, $urandom);
            cfg_write(gpa_pkg::REG_SOFT, $urandom_range(0, 32'h0010_0000));
            run_random(120);
            drain();
        end

        if (!board.failed && board.sums_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gpa_pkg.sv
src/gpa_queue.sv
src/gpa_front.sv
src/gpa_back.sv
src/gravity_pair_accumulate.sv
src/gpa_checker.sv
bench/tb_top.sv
